@@ hdl/assert_macros.svh @@
// Assertion macros used by the scheduler table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/tts_pkg.sv @@
// Types and constants of the tick task scheduler table.
package tts_pkg;

   localparam int TASK_SLOTS  = 8;
   localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int MAX_RESULTS = 8;
   localparam int SENT_W      = $clog2(MAX_RESULTS + 1);
   localparam int RSP_SLOT_W  = 4;
   localparam int TAG_W       = 8;
   localparam int TIME_W      = 16;
   localparam int PEND_W      = 8;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_TICK     = 2'd2,
      CMD_DISPATCH = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_DELETED   = 3'd2,
      KIND_BAD_INDEX = 3'd3,
      KIND_TICKED    = 3'd4,
      KIND_RUN       = 3'd5,
      KIND_NONE_DUE  = 3'd6
   } kind_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] delay;
      logic [TIME_W-1:0] period;
      logic [PEND_W-1:0] pending;
   } slot_entry_type;

endpackage

@@ hdl/tick_task_scheduler_table.sv @@
// Tick task scheduler table: slot memory with read-modify-write walk.
// Add and delete: accepted every cycle while idle, result registered for the next cycle; busy stays low.
// Tick and dispatch: busy for the whole walk; each cycle the walk reads one slot
// and writes back the one read before, up to the last slot.
// Dispatch with nothing due answers in the next cycle; the receiver cannot stall.
// Synchronous reset frees all slots (occupied and due flags cleared).
`include "assert_macros.svh"

module tick_task_scheduler_table
   import tts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [TAG_W-1:0]      req_task_tag,
   input  logic [TIME_W-1:0]     req_start_delay,
   input  logic [TIME_W-1:0]     req_repeat_period,
   input  logic [2:0]            req_slot_index,
   output logic                  rsp_strobe,
   output logic [2:0]            rsp_kind,
   output logic [RSP_SLOT_W-1:0] rsp_slot,
   output logic [TAG_W-1:0]      rsp_run_tag,
   output logic                  rsp_last
);

   localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
   localparam logic [RSP_SLOT_W-1:0] FULL_SLOT = RSP_SLOT_W'(TASK_SLOTS);
   localparam logic [SENT_W-1:0]     SENT_MAX  = SENT_W'(MAX_RESULTS);
   localparam logic [SENT_W-1:0]     SENT_LAST = SENT_W'(MAX_RESULTS - 1);

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   // slot memory and its registered read port
   slot_entry_type slot_mem [TASK_SLOTS];
   slot_entry_type rd_data_ff;

   state_type               state_ff, state_in;
   cmd_type                 op_ff, op_in;
   logic [SLOT_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic                    issue_ff, issue_in;
   logic                    s2_vld_ff, s2_vld_in;
   logic [SLOT_W-1:0]       s2_idx_ff, s2_idx_in;
   logic [TASK_SLOTS-1:0]   occ_ff, occ_in;
   logic [TASK_SLOTS-1:0]   due_ff, due_in;
   logic [SENT_W-1:0]       sent_ff, sent_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic [RSP_SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [TAG_W-1:0]        rsp_tag_ff, rsp_tag_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    mem_wr_en;
   logic [SLOT_W-1:0]       mem_wr_addr;
   slot_entry_type          mem_wr_data;
   logic                    mem_rd_en;

   logic [SLOT_W-1:0]       free_idx;
   logic                    any_free;
   logic [TASK_SLOTS-1:0]   due_above;
   logic                    bad_index;
   logic [SLOT_W-1:0]       del_idx;
   cmd_type                 req_op;
   slot_entry_type          entry_mod;
   logic                    add_del_acc;
   logic                    tick_last;

   assign req_op    = cmd_type'(req_cmd);
   assign bad_index = (int'(req_slot_index) >= TASK_SLOTS);
   assign del_idx   = SLOT_W'(req_slot_index);
   assign mem_rd_en = (state_ff == ST_WALK) && issue_ff;

   // find the lowest free slot
   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int j = TASK_SLOTS - 1; j >= 0; j--) begin
         if (!occ_ff[j]) begin
            free_idx = SLOT_W'(j);
            any_free = 1'b1;
         end
      end
   end

   // mark due slots past the one in the modify stage
   always_comb begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
         due_above[j] = occ_ff[j] && due_ff[j] && (j > int'(s2_idx_ff));
      end
   end

   // next state, flags, memory write and result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_in      = issue_ff;
      s2_vld_in     = mem_rd_en;
      s2_idx_in     = rd_ptr_ff;
      occ_in        = occ_ff;
      due_in        = due_ff;
      sent_in       = sent_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = KIND_ADDED;
      rsp_slot_in   = '0;
      rsp_tag_in    = '0;
      rsp_last_in   = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = s2_idx_ff;
      mem_wr_data   = rd_data_ff;
      entry_mod     = rd_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_op)
                  CMD_ADD: begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     if (any_free) begin
                        mem_wr_en           = 1'b1;
                        mem_wr_addr         = free_idx;
                        mem_wr_data.tag     = req_task_tag;
                        mem_wr_data.delay   = req_start_delay;
                        mem_wr_data.period  = req_repeat_period;
                        mem_wr_data.pending = '0;
                        occ_in[free_idx]    = (req_task_tag != '0);
                        due_in[free_idx]    = 1'b0;
                        rsp_kind_in         = KIND_ADDED;
                        rsp_slot_in         = RSP_SLOT_W'(free_idx);
                     end else begin
                        rsp_kind_in = KIND_FULL;
                        rsp_slot_in = FULL_SLOT;
                     end
                  end
                  CMD_DELETE: begin
                     rsp_strobe_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_slot_in   = RSP_SLOT_W'(req_slot_index);
                     if (bad_index) begin
                        rsp_kind_in = KIND_BAD_INDEX;
                     end else begin
                        occ_in[del_idx] = 1'b0;
                        due_in[del_idx] = 1'b0;
                        rsp_kind_in     = KIND_DELETED;
                     end
                  end
                  CMD_TICK: begin
                     state_in  = ST_WALK;
                     op_in     = CMD_TICK;
                     rd_ptr_in = '0;
                     issue_in  = 1'b1;
                  end
                  CMD_DISPATCH: begin
                     if ((occ_ff & due_ff) == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_kind_in   = KIND_NONE_DUE;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in  = ST_WALK;
                        op_in     = CMD_DISPATCH;
                        rd_ptr_in = '0;
                        issue_in  = 1'b1;
                        sent_in   = '0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_WALK: begin
            // advance the read pointer, stop after the last slot
            if (issue_ff) begin
               if (rd_ptr_ff == LAST_SLOT) begin
                  issue_in = 1'b0;
               end else begin
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end

            // modify the slot read last cycle and write it back
            if (s2_vld_ff) begin
               if (op_ff == CMD_TICK) begin
                  if (occ_ff[s2_idx_ff]) begin
                     mem_wr_en = 1'b1;
                     if (rd_data_ff.delay == '0) begin
                        if (rd_data_ff.pending != '1) begin
                           entry_mod.pending = rd_data_ff.pending + 1'b1;
                        end
                        if (rd_data_ff.period != '0) begin
                           entry_mod.delay = rd_data_ff.period - 1'b1;
                        end
                        due_in[s2_idx_ff] = 1'b1;
                     end else begin
                        entry_mod.delay = rd_data_ff.delay - 1'b1;
                     end
                     mem_wr_data = entry_mod;
                  end
               end else begin
                  if (occ_ff[s2_idx_ff] && due_ff[s2_idx_ff] && (sent_ff != SENT_MAX)) begin
                     rsp_strobe_in     = 1'b1;
                     rsp_kind_in       = KIND_RUN;
                     rsp_slot_in       = RSP_SLOT_W'(s2_idx_ff);
                     rsp_tag_in        = rd_data_ff.tag;
                     rsp_last_in       = (sent_ff == SENT_LAST) || (due_above == '0);
                     sent_in           = sent_ff + 1'b1;
                     entry_mod.pending = rd_data_ff.pending - 1'b1;
                     mem_wr_en         = 1'b1;
                     mem_wr_data       = entry_mod;
                     if (rd_data_ff.period == '0) begin
                        occ_in[s2_idx_ff] = 1'b0;
                        due_in[s2_idx_ff] = 1'b0;
                     end else begin
                        due_in[s2_idx_ff] = (rd_data_ff.pending != PEND_W'(1));
                     end
                  end
               end

               // finish the walk on the last slot
               if (s2_idx_ff == LAST_SLOT) begin
                  state_in = ST_IDLE;
                  if (op_ff == CMD_TICK) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = KIND_TICKED;
                     rsp_slot_in   = '0;
                     rsp_last_in   = 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= slot_mem[rd_ptr_ff];
      end
   end

   // state, flags and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= CMD_TICK;
         rd_ptr_ff     <= '0;
         issue_ff      <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s2_idx_ff     <= '0;
         occ_ff        <= '0;
         due_ff        <= '0;
         sent_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_kind_ff   <= KIND_ADDED;
         rsp_slot_ff   <= '0;
         rsp_tag_ff    <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         rd_ptr_ff     <= rd_ptr_in;
         issue_ff      <= issue_in;
         s2_vld_ff     <= s2_vld_in;
         s2_idx_ff     <= s2_idx_in;
         occ_ff        <= occ_in;
         due_ff        <= due_in;
         sent_ff       <= sent_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_run_tag = rsp_tag_ff;
   assign rsp_last    = rsp_last_ff;

   // conditions watched by the checks below
   assign add_del_acc = start && !busy && ((req_op == CMD_ADD) || (req_op == CMD_DELETE));
   assign tick_last   = (state_ff == ST_WALK) && s2_vld_ff && (s2_idx_ff == LAST_SLOT) &&
                        (op_ff == CMD_TICK);

   // a slot can only be due while it is occupied
   `ASSERT_ALWAYS(a_due_needs_occ, clock, reset, (due_ff & ~occ_ff) == '0)

   // write-back never hits the slot being read in the same cycle
   `ASSERT_IMPLY(a_no_rw_clash, clock, reset, mem_wr_en && mem_rd_en, mem_wr_addr != rd_ptr_ff)

   // add and delete answer in the next cycle with a single final item
   `ASSERT_NEXT(a_single_rsp, clock, reset, add_del_acc, rsp_strobe && rsp_last)

   // the tick walk ends with a ticked item
   `ASSERT_NEXT(a_tick_done, clock, reset, tick_last, rsp_strobe && (rsp_kind == KIND_TICKED) && rsp_last)

endmodule

@@ tb/tick_task_scheduler_table_tb.sv @@
// Self-checking testbench for the tick task scheduler table.
module tick_task_scheduler_table_tb;
   import tts_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 135;

   typedef struct {
      kind_type               kind;
      logic [RSP_SLOT_W-1:0]  slot;
      logic [TAG_W-1:0]       run_tag;
      logic                   last;
   } answer_type;

   typedef struct {
      cmd_type            cmd;
      logic [TAG_W-1:0]   tag;
      logic [TIME_W-1:0]  dly;
      logic [TIME_W-1:0]  per;
      logic [2:0]         idx;
   } command_type;

   typedef struct {
      command_type            c;
      int                     reps;
      bit                     typed;
      kind_type               kind;
      logic [RSP_SLOT_W-1:0]  slot;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_cmd;
   logic [TAG_W-1:0]      req_task_tag;
   logic [TIME_W-1:0]     req_start_delay;
   logic [TIME_W-1:0]     req_repeat_period;
   logic [2:0]            req_slot_index;
   logic                  rsp_strobe;
   logic [2:0]            rsp_kind;
   logic [RSP_SLOT_W-1:0] rsp_slot;
   logic [TAG_W-1:0]      rsp_run_tag;
   logic                  rsp_last;

   // shadow copy of the slot table
   logic [TAG_W-1:0]  shadow_tag    [TASK_SLOTS];
   logic [TIME_W-1:0] shadow_delay  [TASK_SLOTS];
   logic [TIME_W-1:0] shadow_period [TASK_SLOTS];
   logic [PEND_W-1:0] shadow_runs   [TASK_SLOTS];

   answer_type table_answers[$];
   row_type    dir_rows[$];
   bit         cur_typed;
   answer_type cur_answer;
   int         mismatch_count = 0;
   int         cycle_count = 0;
   int         burst_left;

   tick_task_scheduler_table DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_task_tag      (req_task_tag),
      .req_start_delay   (req_start_delay),
      .req_repeat_period (req_repeat_period),
      .req_slot_index    (req_slot_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_kind          (rsp_kind),
      .rsp_slot          (rsp_slot),
      .rsp_run_tag       (rsp_run_tag),
      .rsp_last          (rsp_last)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic push_answer(input kind_type k, input int s, input logic [TAG_W-1:0] t,
                              input logic l);
      answer_type a;
      a.kind = k;
      a.slot = RSP_SLOT_W'(s);
      a.run_tag = t;
      a.last = l;
      table_answers.push_back(a);
   endtask

   task automatic clear_shadow(input int s);
      shadow_tag[s] = '0;
      shadow_delay[s] = '0;
      shadow_period[s] = '0;
      shadow_runs[s] = '0;
   endtask

   // Apply one command to the shadow table and queue the answers it causes.
   task automatic table_command(input command_type c);
      int s;
      int n;
      case (c.cmd)
         CMD_ADD: begin
            s = 0;
            while (s < TASK_SLOTS && shadow_tag[s] != '0) s++;
            if (s == TASK_SLOTS) begin
               push_answer(KIND_FULL, TASK_SLOTS, '0, 1'b1);
            end else begin
               shadow_tag[s] = c.tag;
               shadow_delay[s] = c.dly;
               shadow_period[s] = c.per;
               shadow_runs[s] = '0;
               push_answer(KIND_ADDED, s, '0, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (int'(c.idx) >= TASK_SLOTS) begin
               push_answer(KIND_BAD_INDEX, int'(c.idx), '0, 1'b1);
            end else begin
               clear_shadow(int'(c.idx));
               push_answer(KIND_DELETED, int'(c.idx), '0, 1'b1);
            end
         end
         CMD_TICK: begin
            for (s = 0; s < TASK_SLOTS; s++) begin
               if (shadow_tag[s] != '0) begin
                  if (shadow_delay[s] == '0) begin
                     if (shadow_runs[s] != '1) shadow_runs[s]++;
                     if (shadow_period[s] != '0) shadow_delay[s] = shadow_period[s] - 1'b1;
                  end else begin
                     shadow_delay[s]--;
                  end
               end
            end
            push_answer(KIND_TICKED, 0, '0, 1'b1);
         end
         default: begin
            n = 0;
            for (s = 0; s < TASK_SLOTS && n < MAX_RESULTS; s++) begin
               if (shadow_runs[s] != '0 && shadow_tag[s] != '0) begin
                  push_answer(KIND_RUN, s, shadow_tag[s], 1'b0);
                  n++;
                  shadow_runs[s]--;
                  if (shadow_period[s] == '0) clear_shadow(s);
               end
            end
            if (n == 0) push_answer(KIND_NONE_DUE, 0, '0, 1'b1);
            else table_answers[table_answers.size()-1].last = 1'b1;
         end
      endcase
   endtask

   task automatic cur_answer_check(input answer_type w);
      if (rsp_kind !== w.kind)
         report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, w.kind));
      if (rsp_slot !== w.slot)
         report_mismatch($sformatf("slot %0d, want %0d", rsp_slot, w.slot));
      if (rsp_run_tag !== w.run_tag)
         report_mismatch($sformatf("run_tag %0h, want %0h", rsp_run_tag, w.run_tag));
      if (rsp_last !== w.last)
         report_mismatch($sformatf("last %0b, want %0b", rsp_last, w.last));
   endtask

   // Check results and predict accepted items at the rising edge.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_strobe === 1'b1) begin
            if (table_answers.size() == 0) begin
               report_mismatch($sformatf("result kind %0d slot %0d with nothing outstanding",
                                         rsp_kind, rsp_slot));
            end else begin
               cur_answer_check(table_answers.pop_front());
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            table_command('{cmd_type'(req_cmd), req_task_tag, req_start_delay,
                            req_repeat_period, req_slot_index});
            // swap the predicted answer for the typed one on typed directed rows
            if (cur_typed) begin
               void'(table_answers.pop_back());
               table_answers.push_back(cur_answer);
            end
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Drive one item from a falling edge, hold until accepted, then pace bursts.
   task automatic send(input command_type c, input bit typed, input answer_type a);
      int gap;
      start <= 1'b1;
      req_cmd <= c.cmd;
      req_task_tag <= c.tag;
      req_start_delay <= c.dly;
      req_repeat_period <= c.per;
      req_slot_index <= c.idx;
      cur_typed <= typed;
      cur_answer <= a;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic add_row(input cmd_type cmd, input int tag, input int dly, input int per,
                          input int idx, input int reps, input bit typed,
                          input kind_type kind, input int slot);
      row_type r;
      r.c = '{cmd, TAG_W'(tag), TIME_W'(dly), TIME_W'(per), 3'(idx)};
      r.reps = reps;
      r.typed = typed;
      r.kind = kind;
      r.slot = RSP_SLOT_W'(slot);
      dir_rows.push_back(r);
   endtask

   initial begin
      command_type c;
      answer_type  a;
      row_type     r;
      int          pick;
      int          k;

      reset = 1'b1;
      start = 1'b0;
      req_cmd = CMD_TICK;
      req_task_tag = '0;
      req_start_delay = '0;
      req_repeat_period = '0;
      req_slot_index = '0;
      cur_typed = 1'b0;
      cur_answer = '{KIND_TICKED, '0, '0, 1'b1};
      burst_left = 0;
      for (k = 0; k < TASK_SLOTS; k++) clear_shadow(k);

      // directed table: cmd, tag, delay, period, index, repeats, typed, kind, slot
      add_row(CMD_DISPATCH, 0, 0, 0, 0, 1, 1, KIND_NONE_DUE, 0);
      add_row(CMD_TICK, 0, 0, 0, 0, 1, 1, KIND_TICKED, 0);
      add_row(CMD_ADD, 8'hFF, 0, 0, 0, 1, 1, KIND_ADDED, 0);
      add_row(CMD_ADD, 8'h01, 16'hFFFF, 16'hFFFF, 7, 1, 1, KIND_ADDED, 1);
      // tag zero leaves its slot free, so the next add lands there too
      add_row(CMD_ADD, 8'h00, 5, 7, 0, 1, 1, KIND_ADDED, 2);
      add_row(CMD_ADD, 8'h80, 1, 1, 0, 1, 1, KIND_ADDED, 2);
      add_row(CMD_ADD, 8'h3C, 2, 3, 0, 1, 1, KIND_ADDED, 3);
      add_row(CMD_ADD, 8'h55, 0, 2, 0, 1, 1, KIND_ADDED, 4);
      add_row(CMD_ADD, 8'hAA, 3, 0, 0, 1, 1, KIND_ADDED, 5);
      add_row(CMD_ADD, 8'h7F, 1, 0, 0, 1, 1, KIND_ADDED, 6);
      add_row(CMD_ADD, 8'hC3, 0, 1, 0, 1, 1, KIND_ADDED, 7);
      add_row(CMD_ADD, 8'h11, 4, 4, 0, 1, 1, KIND_FULL, TASK_SLOTS);
      add_row(CMD_DELETE, 0, 0, 0, 7, 1, 1, KIND_DELETED, 7);
      // delete of a free slot still answers deleted
      add_row(CMD_DELETE, 0, 0, 0, 7, 1, 1, KIND_DELETED, 7);
      add_row(CMD_ADD, 8'h99, 0, 0, 0, 1, 1, KIND_ADDED, 7);
      add_row(CMD_TICK, 0, 0, 0, 0, 4, 1, KIND_TICKED, 0);
      // one-shot slots with several runs owed are reported once and freed
      add_row(CMD_DISPATCH, 0, 0, 0, 0, 2, 0, KIND_RUN, 0);
      // let periodic slots pile up several runs each
      add_row(CMD_TICK, 0, 0, 0, 0, 6, 1, KIND_TICKED, 0);
      add_row(CMD_DISPATCH, 0, 0, 0, 0, 3, 0, KIND_RUN, 0);
      add_row(CMD_DELETE, 0, 0, 0, 0, 1, 1, KIND_DELETED, 0);
      add_row(CMD_DELETE, 0, 0, 0, 3, 1, 1, KIND_DELETED, 3);
      add_row(CMD_TICK, 0, 0, 0, 0, 2, 0, KIND_TICKED, 0);
      add_row(CMD_DISPATCH, 0, 0, 0, 0, 1, 0, KIND_RUN, 0);

      // hold reset, then release it on a falling edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         a = '{r.kind, r.slot, '0, 1'b1};
         for (k = 0; k < r.reps; k++) send(r.c, r.typed, a);
      end

      // random commands, biased toward small times so tasks come due often
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) c.cmd = CMD_ADD;
         else if (pick < 40) c.cmd = CMD_DELETE;
         else if (pick < 75) c.cmd = CMD_TICK;
         else c.cmd = CMD_DISPATCH;
         c.tag = ($urandom_range(0, 9) == 0) ? '0 : TAG_W'($urandom_range(1, 255));
         c.dly = ($urandom_range(0, 4) == 0) ? TIME_W'($urandom) :
                 TIME_W'($urandom_range(0, 4));
         pick = $urandom_range(0, 99);
         if (pick < 30) c.per = '0;
         else if (pick < 85) c.per = TIME_W'($urandom_range(1, 4));
         else c.per = TIME_W'($urandom);
         c.idx = 3'($urandom_range(0, 7));
         send(c, 1'b0, a);
      end

      // drain outstanding answers, then allow a full walk of settling time
      start <= 1'b0;
      while (table_answers.size() != 0) @(posedge clock);
      repeat (3 * TASK_SLOTS + 4) @(posedge clock);
      if (mismatch_count == 0 && table_answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
